[src/channel_id_allocator_macros.svh]
// Assertion macros for the channel id allocator.
`ifndef CHANNEL_ID_ALLOCATOR_MACROS_SVH
`define CHANNEL_ID_ALLOCATOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CIA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define CIA_IMPLIES(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

`endif

[src/cia_pkg.sv]
// Types and constants shared by the channel id allocator.
package cia_pkg;

  localparam int unsigned WordBits = 64;

  localparam logic [30:0] POOL_ID_BASE  = 31'd1025;
  localparam logic [30:0] COUNTER_FIRST = 31'd2048;
  localparam logic [30:0] COUNTER_LAST  = 31'h7FFF_FFFE;

  typedef enum logic [1:0] {
    OP_ALLOC_POOL = 2'd0,
    OP_ALLOC_CNT  = 2'd1,
    OP_RELEASE    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_RANGE     = 2'd2,
    STATUS_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] release_id;
  } req_t;

  typedef struct packed {
    logic [30:0] channel_id;
    logic [1:0]  status;
  } rsp_t;

endpackage

[src/channel_id_allocator.sv]
// Channel id allocator: bitmap pool with next-fit search plus a wrapping counter.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request item:
//   allocate a pool id, allocate a counter id, or release a pool id. Output
//   channel (out_valid_o / out_stall_i / out_data_o) returns exactly one result
//   item per request: the granted channel number (zero if none) and a status.
//   Requests are handled one at a time; in_stall_o is low only while idle.
//   A counter id, an unused op or an out-of-range release is answered from the
//   decode state; an in-range release reads its bitmap word, then clears the bit
//   in the release state; a pool grant scans the bitmap word by word.
//   The pool search is set by the bitmap memory's single read port: one
//   64-bit word is scanned per cycle through a shared lowest-free-bit encoder,
//   starting after the last granted slot and wrapping back to it.
//   At reset the bitmap memory is swept clear, one word per cycle; no request
//   is taken meanwhile. A stalled result stays in the output register; the next
//   request may be accepted meanwhile and is held before completion until that
//   register frees.
`include "channel_id_allocator_macros.svh"

module channel_id_allocator #(
  parameter int unsigned POOL_SIZE = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cia_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cia_pkg::rsp_t out_data_o
);

  localparam int unsigned MAP_WORDS = (POOL_SIZE + cia_pkg::WordBits - 1) / cia_pkg::WordBits;
  localparam int unsigned SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int unsigned VIS_W     = $clog2(MAP_WORDS + 2);
  localparam int unsigned EXT_W     = SLOT_W + 6;
  localparam int unsigned TAIL_BITS = POOL_SIZE - cia_pkg::WordBits * (MAP_WORDS - 1);
  localparam logic [63:0] TAIL_MASK = {64{1'b1}} >> (64 - TAIL_BITS);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);
  localparam logic [30:0] REL_HI = 31'(1024 + POOL_SIZE);

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_DECODE  = 5'b00100,
    ST_SCAN    = 5'b01000,
    ST_RELEASE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  cia_pkg::req_t req_q, req_d;
  logic [SLOT_W-1:0] last_slot_q, last_slot_d;
  logic [CNT_W-1:0]  used_count_q, used_count_d;
  logic [30:0]       next_id_q, next_id_d;

  // Scan bookkeeping: issue side and check side of the word pipeline.
  logic [WORD_W-1:0] iss_word_q, iss_word_d;
  logic [VIS_W-1:0]  iss_cnt_q, iss_cnt_d;
  logic [5:0]        start_bit_q, start_bit_d;
  logic              chk_valid_q, chk_valid_d;
  logic              chk_first_q, chk_first_d;
  logic              chk_final_q, chk_final_d;
  logic [WORD_W-1:0] chk_word_q, chk_word_d;

  logic          out_valid_q, out_valid_d;
  cia_pkg::rsp_t out_q, out_d;
  logic          out_free, out_load;

  // Bitmap memory: one write port, one registered read port.
  logic [63:0]       mem [MAP_WORDS];
  logic              mem_we, mem_re;
  logic [WORD_W-1:0] mem_waddr, mem_raddr;
  logic [63:0]       mem_wdata, rd_data_q;

  // Slot arithmetic.
  logic [SLOT_W-1:0] start_slot, rel_slot, grant_slot;
  logic [EXT_W-1:0]  start_ext, rel_ext;
  logic              rel_in_range;

  // Shared lowest-free-bit encoder.
  logic [63:0] vis_mask, start_mask, free_w, lowest;
  logic [5:0]  hit_bit;
  logic        scan_hit, issue;

  assign out_free = !out_valid_q || !out_stall_i;

  assign start_slot = (last_slot_q == LAST_SLOT) ? '0 : last_slot_q + SLOT_W'(1);
  assign start_ext  = EXT_W'(start_slot);

  assign rel_in_range = (req_q.release_id >= cia_pkg::POOL_ID_BASE) &&
                        (req_q.release_id <= REL_HI);
  assign rel_slot = SLOT_W'(req_q.release_id - cia_pkg::POOL_ID_BASE);
  assign rel_ext  = EXT_W'(rel_slot);

  always_comb begin
    vis_mask = (chk_word_q == LAST_WORD) ? TAIL_MASK : {64{1'b1}};
    start_mask = {64{1'b1}};
    if (chk_first_q) begin
      start_mask = {64{1'b1}} << start_bit_q;
    end else if (chk_final_q) begin
      start_mask = ~({64{1'b1}} << start_bit_q);
    end
    free_w = ~rd_data_q & vis_mask & start_mask;
    lowest = free_w & (~free_w + 64'd1);
    hit_bit = '0;
    for (int i = 0; i < 64; i++) begin
      if (lowest[i]) begin
        hit_bit = hit_bit | 6'(i);
      end
    end
  end

  assign scan_hit   = chk_valid_q && (free_w != '0);
  assign grant_slot = SLOT_W'({chk_word_q, hit_bit});
  assign issue      = (iss_cnt_q <= VIS_W'(MAP_WORDS));

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    last_slot_d  = last_slot_q;
    used_count_d = used_count_q;
    next_id_d    = next_id_q;
    iss_word_d   = iss_word_q;
    iss_cnt_d    = iss_cnt_q;
    start_bit_d  = start_bit_q;
    chk_valid_d  = 1'b0;
    chk_first_d  = chk_first_q;
    chk_final_d  = chk_final_q;
    chk_word_d   = chk_word_q;
    out_load     = 1'b0;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = iss_word_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = iss_word_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the bitmap clear, one word per cycle.
        mem_we = 1'b1;
        if (iss_word_q == LAST_WORD) begin
          iss_word_d = '0;
          state_d    = ST_IDLE;
        end else begin
          iss_word_d = iss_word_q + WORD_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        // Hold until the output register can take this item's result.
        if (out_free) begin
          unique case (req_q.op)
            cia_pkg::OP_ALLOC_POOL: begin
              if (used_count_q >= CNT_W'(POOL_SIZE)) begin
                out_load = 1'b1;
                out_d    = '{channel_id: '0, status: cia_pkg::STATUS_FULL};
                state_d  = ST_IDLE;
              end else begin
                iss_word_d  = start_ext[6 +: WORD_W];
                start_bit_d = start_ext[5:0];
                iss_cnt_d   = '0;
                state_d     = ST_SCAN;
              end
            end
            cia_pkg::OP_ALLOC_CNT: begin
              out_load  = 1'b1;
              out_d     = '{channel_id: next_id_q, status: cia_pkg::STATUS_OK};
              next_id_d = (next_id_q == cia_pkg::COUNTER_LAST) ?
                          cia_pkg::COUNTER_FIRST : next_id_q + 31'd1;
              state_d   = ST_IDLE;
            end
            cia_pkg::OP_RELEASE: begin
              if (rel_in_range) begin
                mem_re    = 1'b1;
                mem_raddr = rel_ext[6 +: WORD_W];
                state_d   = ST_RELEASE;
              end else begin
                out_load = 1'b1;
                out_d    = '{channel_id: '0, status: cia_pkg::STATUS_RANGE};
                state_d  = ST_IDLE;
              end
            end
            default: begin
              out_load = 1'b1;
              out_d    = '{channel_id: '0, status: cia_pkg::STATUS_OK};
              state_d  = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next word read while checking the word read last cycle.
        if (issue) begin
          mem_re      = 1'b1;
          mem_raddr   = iss_word_q;
          chk_valid_d = 1'b1;
          chk_word_d  = iss_word_q;
          chk_first_d = (iss_cnt_q == '0);
          chk_final_d = (iss_cnt_q == VIS_W'(MAP_WORDS));
          iss_cnt_d   = iss_cnt_q + VIS_W'(1);
          iss_word_d  = (iss_word_q == LAST_WORD) ? '0 : iss_word_q + WORD_W'(1);
        end
        if (scan_hit) begin
          mem_we       = 1'b1;
          mem_waddr    = chk_word_q;
          mem_wdata    = rd_data_q | lowest;
          last_slot_d  = grant_slot;
          used_count_d = used_count_q + CNT_W'(1);
          out_load     = 1'b1;
          out_d        = '{channel_id: cia_pkg::POOL_ID_BASE + 31'(grant_slot),
                           status: cia_pkg::STATUS_OK};
          chk_valid_d  = 1'b0;
          state_d      = ST_IDLE;
        end else if (chk_valid_q && chk_final_q) begin
          out_load    = 1'b1;
          out_d       = '{channel_id: '0, status: cia_pkg::STATUS_FULL};
          chk_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      ST_RELEASE: begin
        // Clear the slot's bit; drop the count unless it is already zero.
        mem_we    = 1'b1;
        mem_waddr = rel_ext[6 +: WORD_W];
        mem_wdata = rd_data_q & ~(64'd1 << rel_ext[5:0]);
        out_load  = 1'b1;
        if (used_count_q != '0) begin
          used_count_d = used_count_q - CNT_W'(1);
          out_d        = '{channel_id: '0, status: cia_pkg::STATUS_OK};
        end else begin
          out_d = '{channel_id: '0, status: cia_pkg::STATUS_UNDERFLOW};
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      last_slot_q  <= '0;
      used_count_q <= '0;
      next_id_q    <= cia_pkg::COUNTER_FIRST;
      iss_word_q   <= '0;
      iss_cnt_q    <= '0;
      chk_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_slot_q  <= last_slot_d;
      used_count_q <= used_count_d;
      next_id_q    <= next_id_d;
      iss_word_q   <= iss_word_d;
      iss_cnt_q    <= iss_cnt_d;
      chk_valid_q  <= chk_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    start_bit_q <= start_bit_d;
    chk_first_q <= chk_first_d;
    chk_final_q <= chk_final_d;
    chk_word_q  <= chk_word_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CIA_ASSERT(a_count_bound, used_count_q <= CNT_W'(POOL_SIZE), "used count above pool size")
  `CIA_IMPLIES(a_load_free, out_load, !out_valid_q || !out_stall_i,
               "result overwrote a pending output item")
  `CIA_IMPLIES(a_hit_free, state_q == ST_SCAN && scan_hit,
               !rd_data_q[hit_bit] && ((WORD_W + 7)'({chk_word_q, hit_bit}) < (WORD_W + 7)'(POOL_SIZE)),
               "granted slot was used or outside the pool")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the channel id allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PoolSize = 1024;
  // Selector value that the block decodes to no action.
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles to keep watching after the last expected grant: covers a full
  // pool scan plus stalls on the result side.
  localparam int unsigned SettleCycles = 60;

  // Tracks the allocator's state and queues the result expected for each
  // accepted request, oldest first.
  class grant_board;
    bit [PoolSize-1:0] slot_taken;
    int unsigned       last_slot;
    int unsigned       used_count;
    logic [30:0]       next_counter_id;
    cia_pkg::rsp_t     pending_grants[$];
    int unsigned       mismatches;
    bit                saw_full;

    function new();
      slot_taken      = '0;
      last_slot       = 0;
      used_count      = 0;
      next_counter_id = cia_pkg::COUNTER_FIRST;
      mismatches      = 0;
      saw_full        = 1'b0;
    endfunction

    // Work out the grant for one request and advance the tracked state.
    function cia_pkg::rsp_t grant_for(cia_pkg::req_t req);
      cia_pkg::rsp_t rsp;
      int unsigned   s;
      int unsigned   rel;
      rsp.channel_id = '0;
      rsp.status     = cia_pkg::STATUS_OK;
      case (req.op)
        cia_pkg::OP_ALLOC_POOL: begin
          rsp.status = cia_pkg::STATUS_FULL;
          if (used_count < PoolSize) begin
            s = last_slot;
            // Start after the last grant, wrap, and try the last grant itself last.
            for (int k = 0; k < PoolSize; k++) begin
              s = (s + 1) % PoolSize;
              if (!slot_taken[s]) begin
                slot_taken[s]  = 1'b1;
                last_slot      = s;
                used_count++;
                rsp.channel_id = cia_pkg::POOL_ID_BASE + 31'(s);
                rsp.status     = cia_pkg::STATUS_OK;
                break;
              end
            end
          end
          if (rsp.status == cia_pkg::STATUS_FULL) saw_full = 1'b1;
        end
        cia_pkg::OP_ALLOC_CNT: begin
          rsp.channel_id = next_counter_id;
          if (next_counter_id == cia_pkg::COUNTER_LAST) begin
            next_counter_id = cia_pkg::COUNTER_FIRST;
          end else begin
            next_counter_id = next_counter_id + 31'd1;
          end
        end
        cia_pkg::OP_RELEASE: begin
          rel = req.release_id;
          if (rel < cia_pkg::POOL_ID_BASE || rel > cia_pkg::POOL_ID_BASE + PoolSize - 1) begin
            rsp.status = cia_pkg::STATUS_RANGE;
          end else begin
            // The count drops even when the slot was already free.
            if (used_count > 0) used_count--;
            else rsp.status = cia_pkg::STATUS_UNDERFLOW;
            slot_taken[rel - cia_pkg::POOL_ID_BASE] = 1'b0;
          end
        end
        default: ;
      endcase
      return rsp;
    endfunction

    function void note_request(cia_pkg::req_t req);
      pending_grants.push_back(grant_for(req));
    endfunction

    function void check_grant(cia_pkg::rsp_t got);
      cia_pkg::rsp_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %0d status %0d",
                 $time, got.channel_id, got.status);
        mismatches++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.channel_id !== want.channel_id) begin
        $display("%0t: channel_id mismatch, expected %0d, actual %0d",
                 $time, want.channel_id, got.channel_id);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_grants.size();
    endfunction
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          out_stall_i = 1'b0;
  cia_pkg::req_t in_data_i   = '0;
  logic          in_stall_o;
  logic          out_valid_o;
  cia_pkg::rsp_t out_data_o;

  grant_board  board;
  bit          steady;     // high while neither side may idle
  int unsigned sent_items;

  channel_id_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the result side about 11 times in a hundred, except in the steady window.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 11);
  end

  // Check every result taken at this edge; values read here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_grant(out_data_o);
  end

  function automatic cia_pkg::req_t make_req(logic [1:0] op, logic [30:0] id);
    cia_pkg::req_t req;
    req.op         = op;
    req.release_id = id;
    return req;
  endfunction

  function automatic logic [30:0] pool_id_at_random();
    return cia_pkg::POOL_ID_BASE + 31'($urandom_range(PoolSize - 1));
  endfunction

  // Pick an id that sits on or just past an edge of the release range, or at either end of the id field.
  function automatic logic [30:0] edge_id();
    case ($urandom_range(5))
      0: return 31'd0;
      1: return cia_pkg::POOL_ID_BASE - 31'd1;
      2: return cia_pkg::POOL_ID_BASE;
      3: return cia_pkg::POOL_ID_BASE + 31'(PoolSize - 1);
      4: return cia_pkg::POOL_ID_BASE + 31'(PoolSize);
      default: return 31'h7FFF_FFFF;
    endcase
  endfunction

  // Fill mode pushes the pool toward exhaustion; mixed mode churns a busy pool.
  function automatic cia_pkg::req_t random_request(bit fill_mode);
    int unsigned pick;
    pick = $urandom_range(99);
    if (fill_mode) begin
      if (pick < 93) return make_req(cia_pkg::OP_ALLOC_POOL, 31'($urandom()));
      if (pick < 95) return make_req(cia_pkg::OP_ALLOC_CNT, 31'($urandom()));
      if (pick < 98) return make_req(cia_pkg::OP_RELEASE, pool_id_at_random());
      if (pick < 99) return make_req(OpUnused, 31'($urandom()));
      return make_req(cia_pkg::OP_RELEASE, 31'($urandom()));
    end
    if (pick < 40) return make_req(cia_pkg::OP_ALLOC_POOL, 31'($urandom()));
    if (pick < 48) return make_req(cia_pkg::OP_ALLOC_CNT, 31'($urandom()));
    if (pick < 88) return make_req(cia_pkg::OP_RELEASE, pool_id_at_random());
    if (pick < 94) return make_req(cia_pkg::OP_RELEASE, 31'($urandom()));
    if (pick < 97) return make_req(cia_pkg::OP_RELEASE, edge_id());
    return make_req(OpUnused, 31'($urandom()));
  endfunction

  // Offer one item, idling first at random, and hold it until the block takes it.
  task automatic send_item(cia_pkg::req_t req);
    steady = (sent_items >= 200 && sent_items < 450);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req);
    sent_items++;
  endtask

  task automatic wait_for_grants();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned fill_items;
    board      = new();
    steady     = 1'b0;
    sent_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: release edges on an empty pool, ignored selector, first grants
    // after reset, counter grants, double release of a slot, then underflow and fresh grants.
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE - 31'd1));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE + 31'(PoolSize)));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE + 31'(PoolSize - 1)));
    send_item(make_req(cia_pkg::OP_RELEASE, 31'd0));
    send_item(make_req(cia_pkg::OP_RELEASE, 31'h7FFF_FFFF));
    send_item(make_req(OpUnused, 31'h7FFF_FFFF));
    send_item(make_req(OpUnused, 31'd0));
    send_item(make_req(cia_pkg::OP_ALLOC_POOL, 31'd0));
    send_item(make_req(cia_pkg::OP_ALLOC_POOL, 31'h7FFF_FFFF));
    send_item(make_req(cia_pkg::OP_ALLOC_CNT, 31'h7FFF_FFFF));
    send_item(make_req(cia_pkg::OP_ALLOC_CNT, 31'd0));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE + 31'd1));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE + 31'd1));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE + 31'd1));
    send_item(make_req(cia_pkg::OP_RELEASE, cia_pkg::POOL_ID_BASE + 31'd2));
    send_item(make_req(cia_pkg::OP_ALLOC_POOL, 31'd0));
    send_item(make_req(cia_pkg::OP_ALLOC_POOL, 31'h5555_5555));

    // Pause the sender until every grant so far has come back.
    in_valid_i <= 1'b0;
    wait_for_grants();

    // Fill the pool until a full result is expected (at most 1600 items), then churn it.
    fill_items = 0;
    while (!board.saw_full && fill_items < 1600) begin
      send_item(random_request(1'b1));
      fill_items++;
    end
    repeat (80) send_item(random_request(1'b0));

    in_valid_i <= 1'b0;
    steady = 1'b0;
    wait_for_grants();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("channel_id_allocator regression: pass");
    end else begin
      $display("channel_id_allocator regression: fail");
    end
    $finish;
  end

  // Drop the run if it hangs.
  initial begin
    #1_000_000;
    $display("channel_id_allocator regression: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/cia_pkg.sv
src/channel_id_allocator.sv
verif/tb_top.sv
